@@ hdl/sbrf_pkg.sv @@
`default_nettype none

package sbrf_pkg;

    // Store geometry and frame shape
    localparam int BIN_COUNT        = 256;
    localparam int VALUES_PER_FRAME = 8;
    localparam int MAX_FRAMES       = 32;
    localparam int SLOT_COUNT       = 8;
    localparam int SLOT_W           = 3;
    localparam int ADDR_W           = $clog2(BIN_COUNT);
    localparam int IDX_W            = 8;
    localparam int CMP_W            = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
    localparam int CNT_W            = 4;
    localparam int FRM_W            = 6;
    localparam int DATA_W           = 32;
    localparam int VAL_W            = 16;
    localparam int SHIFT_W          = 5;
    localparam int CMD_W            = 8;
    localparam int ERR_W            = 2;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

    // Request queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Ceiling frame count by reciprocal multiply, exact for counts below 2^10
    localparam int RECIP_SH = 16;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int RECIP    = (2 ** RECIP_SH + VALUES_PER_FRAME - 1) / VALUES_PER_FRAME;
    localparam int SPAN_W   = IDX_W + 2;
    localparam int PROD_W   = SPAN_W + RECIP_W;

    // Input codes
    localparam logic             FUNC_WRITE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SINGLE = 8'd0;
    localparam logic [CMD_W-1:0] CMD_RANGE  = 8'd1;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_ARG = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_CMD = 2'd2;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_RANGE  = 2'd1,
        KIND_ERROR  = 2'd2
    } reply_kind_t;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_ERROR
    } op_t;

    typedef logic [ADDR_W-1:0] addr_t;

    // One classified request
    typedef struct packed {
        op_t                op;
        reply_kind_t        kind;
        logic [ERR_W-1:0]   err;
        logic [IDX_W-1:0]   first;
        logic [IDX_W-1:0]   last;
        logic [FRM_W-1:0]   frames;
        logic [DATA_W-1:0]  data;
    } req_t;

    function automatic addr_t to_addr(input logic [IDX_W-1:0] b);
        logic [ADDR_W+IDX_W-1:0] w;
        w = (ADDR_W + IDX_W)'(b);
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] b);
        return (CMP_W'(b) < CMP_W'(BIN_COUNT));
    endfunction

    // Values in the frame starting at idx, capped at one frame
    function automatic logic [CNT_W-1:0] frame_cnt(input logic [IDX_W-1:0] idx,
                                                   input logic [IDX_W-1:0] last);
        logic [IDX_W:0] left;
        left = ({1'b0, last} - {1'b0, idx}) + (IDX_W + 1)'(1);
        if (left > (IDX_W + 1)'(VALUES_PER_FRAME)) begin
            return CNT_W'(VALUES_PER_FRAME);
        end
        return left[CNT_W-1:0];
    endfunction

    // Arithmetic shift, then clamp to 0..65535
    function automatic logic [VAL_W-1:0] scale_bin(input logic [DATA_W-1:0]  raw,
                                                   input logic [SHIFT_W-1:0] sh);
        logic [DATA_W-1:0] v;
        v = raw >> sh;
        if (raw[DATA_W-1]) begin
            return '0;
        end
        if (|v[DATA_W-1:VAL_W]) begin
            return '1;
        end
        return v[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/sbrf_front.sv @@
`default_nettype none

module sbrf_front import sbrf_pkg::*; (
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_func,
    input  wire logic [CMD_W-1:0]   s_command_code,
    input  wire logic [IDX_W-1:0]   s_first_bin,
    input  wire logic [IDX_W-1:0]   s_last_bin,
    input  wire logic [DATA_W-1:0]  s_bin_data,
    input  wire logic               q_full,
    output logic                    q_push,
    output req_t                    q_req
);

    logic [IDX_W:0]       span;
    logic [SPAN_W-1:0]    span_up;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W-RECIP_SH-1:0] frames_w;
    logic                 keep;

    // Frame count = ceil(span / VALUES_PER_FRAME)
    assign span     = ({1'b0, s_last_bin} - {1'b0, s_first_bin}) + (IDX_W + 1)'(1);
    assign span_up  = SPAN_W'(span) + SPAN_W'(VALUES_PER_FRAME - 1);
    assign prod     = PROD_W'(span_up) * PROD_W'(RECIP);
    assign frames_w = prod[PROD_W-1:RECIP_SH];

    assign s_ready = !q_full;

    // Classify the request
    always_comb begin
        q_req.op     = OP_ERROR;
        q_req.kind   = KIND_ERROR;
        q_req.err    = ERR_BAD_CMD;
        q_req.first  = s_first_bin;
        q_req.last   = s_last_bin;
        q_req.frames = FRM_W'(1);
        q_req.data   = s_bin_data;
        keep         = 1'b1;
        if (s_func == FUNC_WRITE) begin
            q_req.op = OP_WRITE;
            keep     = in_range(s_first_bin);
        end else begin
            case (s_command_code)
                CMD_SINGLE: begin
                    q_req.last = s_first_bin;
                    if (in_range(s_first_bin)) begin
                        q_req.op   = OP_READ;
                        q_req.kind = KIND_SINGLE;
                        q_req.err  = ERR_NONE;
                    end else begin
                        q_req.err = ERR_BAD_ARG;
                    end
                end
                CMD_RANGE: begin
                    if (s_first_bin > s_last_bin || !in_range(s_last_bin) ||
                        frames_w > (PROD_W - RECIP_SH)'(MAX_FRAMES)) begin
                        q_req.err = ERR_BAD_ARG;
                    end else begin
                        q_req.op     = OP_READ;
                        q_req.kind   = KIND_RANGE;
                        q_req.err    = ERR_NONE;
                        q_req.frames = FRM_W'(frames_w);
                    end
                end
                default: begin
                    q_req.err = ERR_BAD_CMD;
                end
            endcase
        end
    end

    // Out-of-range writes are dropped here
    assign q_push = s_valid && s_ready && keep;

endmodule

`default_nettype wire

@@ hdl/sbrf_queue.sv @@
`default_nettype none

module sbrf_queue import sbrf_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire req_t  push_req,
    input  wire logic  pop,
    output req_t       head,
    output logic       empty,
    output logic       full
);

    req_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_PTR_W:0]    count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (Q_PTR_W + 1)'(Q_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (Q_PTR_W + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (Q_PTR_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/sbrf_back.sv @@
`default_nettype none

module sbrf_back import sbrf_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_empty,
    input  wire req_t               q_head,
    output logic                    q_pop,
    input  wire logic [SHIFT_W-1:0] output_shift,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_reply_kind,
    output logic [ERR_W-1:0]        m_status_code,
    output logic [FRM_W-1:0]        m_frame_total,
    output logic [FRM_W-1:0]        m_frame_number,
    output logic [CNT_W-1:0]        m_value_count,
    output logic [IDX_W-1:0]        m_start_index,
    output logic [4*VAL_W-1:0]      m_values_front,
    output logic [4*VAL_W-1:0]      m_values_back,
    output logic                    m_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_SEND
    } state_t;

    state_t               state_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     last_reg;
    logic [FRM_W-1:0]     frames_reg;
    logic [FRM_W-1:0]     fnum_reg;
    reply_kind_t          kind_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     issue_reg;
    logic [CNT_W-1:0]     recv_reg;
    logic [VAL_W-1:0]     slot_reg [SLOT_COUNT];
    logic                 rd_en_reg;
    logic [SLOT_W-1:0]    rd_slot_reg;

    // Bin store, with a valid bit per bin standing in for the reset clear
    logic [DATA_W-1:0]    store_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0] bin_vld_reg;
    logic [DATA_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;

    // Output register
    logic                 m_valid_reg;
    reply_kind_t          out_kind_reg;
    logic [ERR_W-1:0]     out_err_reg;
    logic [FRM_W-1:0]     out_total_reg;
    logic [FRM_W-1:0]     out_number_reg;
    logic [CNT_W-1:0]     out_count_reg;
    logic [IDX_W-1:0]     out_start_reg;
    logic [4*VAL_W-1:0]   out_front_reg;
    logic [4*VAL_W-1:0]   out_back_reg;
    logic                 out_last_reg;

    logic                 wr_en;
    addr_t                wr_addr;
    logic                 rd_en;
    addr_t                rd_addr;
    logic [IDX_W-1:0]     next_idx;
    logic [VAL_W-1:0]     scaled;
    logic [4*VAL_W-1:0]   pack_front;
    logic [4*VAL_W-1:0]   pack_back;

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign wr_en    = q_pop && (q_head.op == OP_WRITE);
    assign wr_addr  = to_addr(q_head.first);
    assign rd_en    = (state_reg == ST_FILL) && (issue_reg < cnt_reg);
    assign rd_addr  = to_addr(idx_reg + IDX_W'(issue_reg));
    assign next_idx = idx_reg + IDX_W'(cnt_reg);
    assign scaled   = rd_vld_reg ? scale_bin(rd_data_reg, output_shift) : '0;

    // Pack slots, first value in the top bits
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pack_front[(3 - i) * VAL_W +: VAL_W] = slot_reg[i];
            pack_back[(3 - i) * VAL_W +: VAL_W]  = slot_reg[i + 4];
        end
    end

    // Store write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= q_head.data;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
            rd_vld_reg  <= bin_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_vld_reg <= '0;
        end else if (wr_en) begin
            bin_vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Sequencer: frame fill and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            rd_en_reg   <= 1'b0;
            issue_reg   <= '0;
            recv_reg    <= '0;
        end else begin
            rd_en_reg   <= rd_en;
            rd_slot_reg <= issue_reg[SLOT_W-1:0];
            if (rd_en) begin
                issue_reg <= issue_reg + CNT_W'(1);
            end
            if (rd_en_reg) begin
                slot_reg[rd_slot_reg] <= scaled;
                recv_reg              <= recv_reg + CNT_W'(1);
            end

            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        case (q_head.op)
                            OP_READ: begin
                                idx_reg    <= q_head.first;
                                last_reg   <= q_head.last;
                                frames_reg <= q_head.frames;
                                fnum_reg   <= FRM_W'(1);
                                kind_reg   <= q_head.kind;
                                cnt_reg    <= frame_cnt(q_head.first, q_head.last);
                                issue_reg  <= '0;
                                recv_reg   <= '0;
                                for (int i = 0; i < SLOT_COUNT; i++) begin
                                    slot_reg[i] <= '0;
                                end
                                state_reg  <= ST_FILL;
                            end
                            OP_ERROR: begin
                                out_kind_reg   <= KIND_ERROR;
                                out_err_reg    <= q_head.err;
                                out_total_reg  <= '0;
                                out_number_reg <= '0;
                                out_count_reg  <= '0;
                                out_start_reg  <= '0;
                                out_front_reg  <= '0;
                                out_back_reg   <= '0;
                                out_last_reg   <= 1'b1;
                                m_valid_reg    <= 1'b1;
                                state_reg      <= ST_SEND;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_FILL: begin
                    // all reads of this frame captured
                    if (recv_reg == cnt_reg) begin
                        out_kind_reg   <= kind_reg;
                        out_err_reg    <= ERR_NONE;
                        out_total_reg  <= frames_reg;
                        out_number_reg <= fnum_reg;
                        out_count_reg  <= cnt_reg;
                        out_start_reg  <= idx_reg;
                        out_front_reg  <= pack_front;
                        out_back_reg   <= pack_back;
                        out_last_reg   <= (fnum_reg == frames_reg);
                        m_valid_reg    <= 1'b1;
                        state_reg      <= ST_SEND;
                    end
                end
                ST_SEND: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (out_last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= next_idx;
                            fnum_reg  <= fnum_reg + FRM_W'(1);
                            cnt_reg   <= frame_cnt(next_idx, last_reg);
                            issue_reg <= '0;
                            recv_reg  <= '0;
                            for (int i = 0; i < SLOT_COUNT; i++) begin
                                slot_reg[i] <= '0;
                            end
                            state_reg <= ST_FILL;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_reply_kind   = out_kind_reg;
    assign m_status_code  = out_err_reg;
    assign m_frame_total  = out_total_reg;
    assign m_frame_number = out_number_reg;
    assign m_value_count  = out_count_reg;
    assign m_start_index  = out_start_reg;
    assign m_values_front = out_front_reg;
    assign m_values_back  = out_back_reg;
    assign m_last         = out_last_reg;

endmodule

`default_nettype wire

@@ hdl/spectrum_bin_readout_framer.sv @@
// From request accept to m_valid: an error reply is loaded into the output at queue pop, and
// a single bin goes through queue pop, store read, capture and output load, as does a range.
// Each further frame of a range is filled once m_ready accepts the one on the output; its reads
// issue one per cycle; store writes retire one per cycle while the sequencer is idle.
// A 4-entry queue takes requests while a reply drains; s_ready drops once it is full.
// Reset (aresetn low, synchronous) empties the queue, clears all bins via per-bin valid bits,
// drops m_valid and sets output_shift to 12.
`default_nettype none

module spectrum_bin_readout_framer import sbrf_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [SHIFT_W-1:0] cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_func,
    input  wire logic [CMD_W-1:0]   s_command_code,
    input  wire logic [IDX_W-1:0]   s_first_bin,
    input  wire logic [IDX_W-1:0]   s_last_bin,
    input  wire logic [DATA_W-1:0]  s_bin_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_reply_kind,
    output logic [ERR_W-1:0]        m_status_code,
    output logic [FRM_W-1:0]        m_frame_total,
    output logic [FRM_W-1:0]        m_frame_number,
    output logic [CNT_W-1:0]        m_value_count,
    output logic [IDX_W-1:0]        m_start_index,
    output logic [4*VAL_W-1:0]      m_values_front,
    output logic [4*VAL_W-1:0]      m_values_back,
    output logic                    m_last
);

    logic [SHIFT_W-1:0] output_shift_reg;
    logic               q_push;
    req_t               q_req;
    logic               q_pop;
    req_t               q_head;
    logic               q_empty;
    logic               q_full;

    // Shift register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_shift_reg <= SHIFT_RESET;
        end else if (cfg_wr_en) begin
            output_shift_reg <= cfg_wr_data;
        end
    end

    sbrf_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_command_code (s_command_code),
        .s_first_bin    (s_first_bin),
        .s_last_bin     (s_last_bin),
        .s_bin_data     (s_bin_data),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_req          (q_req)
    );

    sbrf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_req (q_req),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    sbrf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .output_shift   (output_shift_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reply_kind   (m_reply_kind),
        .m_status_code  (m_status_code),
        .m_frame_total  (m_frame_total),
        .m_frame_number (m_frame_number),
        .m_value_count  (m_value_count),
        .m_start_index  (m_start_index),
        .m_values_front (m_values_front),
        .m_values_back  (m_values_back),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire

@@ hdl/sbrf_checker.sv @@
`default_nettype none

module sbrf_checker import sbrf_pkg::*; (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [1:0]         m_reply_kind,
    input wire logic [ERR_W-1:0]   m_status_code,
    input wire logic [FRM_W-1:0]   m_frame_total,
    input wire logic [FRM_W-1:0]   m_frame_number,
    input wire logic [CNT_W-1:0]   m_value_count,
    input wire logic [IDX_W-1:0]   m_start_index,
    input wire logic [4*VAL_W-1:0] m_values_front,
    input wire logic [4*VAL_W-1:0] m_values_back,
    input wire logic               m_last
);

    // A stalled reply holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reply_kind) && $stable(m_frame_number)
            && $stable(m_values_front) && $stable(m_values_back) && $stable(m_last))
        else $error("reply changed while stalled");

    // Error replies carry only kind and code
    a_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reply_kind == KIND_ERROR |->
            m_last && m_frame_total == '0 && m_value_count == '0 &&
            m_start_index == '0 && m_values_front == '0 && m_values_back == '0 &&
            (m_status_code == ERR_BAD_ARG || m_status_code == ERR_BAD_CMD))
        else $error("malformed error reply");

    // Frame numbering, value count and last flag agree
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reply_kind == KIND_RANGE |->
            m_frame_number != '0 && m_frame_number <= m_frame_total &&
            m_value_count != '0 && m_value_count <= CNT_W'(VALUES_PER_FRAME) &&
            (m_last == (m_frame_number == m_frame_total)))
        else $error("range frame numbering inconsistent");

    // Single-bin reply is one frame of one value
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reply_kind == KIND_SINGLE |->
            m_last && m_frame_total == FRM_W'(1) && m_frame_number == FRM_W'(1) &&
            m_value_count == CNT_W'(1) && m_values_back == '0 &&
            m_values_front[3*VAL_W-1:0] == '0)
        else $error("malformed single-bin reply");

endmodule

bind spectrum_bin_readout_framer sbrf_checker u_sbrf_checker (.*);

`default_nettype wire

@@ dv/spectrum_bin_readout_framer_tb.sv @@
module spectrum_bin_readout_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbrf_pkg::*;

    localparam logic FUNC_HOST       = ~FUNC_WRITE;
    localparam int   SETTLE_CYCLES   = 16;
    localparam int   HOLD_OFF_CYCLES = 400;
    localparam int   RANDOM_PHASES   = 4;
    localparam int   PHASE_REQUESTS  = 80;

    // One expected reply or range frame
    typedef struct packed {
        reply_kind_t        kind;
        logic [ERR_W-1:0]   err;
        logic [FRM_W-1:0]   total;
        logic [FRM_W-1:0]   number;
        logic [CNT_W-1:0]   count;
        logic [IDX_W-1:0]   start;
        logic [4*VAL_W-1:0] front;
        logic [4*VAL_W-1:0] back;
        logic               last;
    } bin_frame_t;

    logic               aclk;
    logic               aresetn        = 1'b0;
    logic               cfg_wr_en      = 1'b0;
    logic [SHIFT_W-1:0] cfg_wr_data    = '0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic               s_func         = FUNC_WRITE;
    logic [CMD_W-1:0]   s_command_code = '0;
    logic [IDX_W-1:0]   s_first_bin    = '0;
    logic [IDX_W-1:0]   s_last_bin     = '0;
    logic [DATA_W-1:0]  s_bin_data     = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [1:0]         m_reply_kind;
    logic [ERR_W-1:0]   m_status_code;
    logic [FRM_W-1:0]   m_frame_total;
    logic [FRM_W-1:0]   m_frame_number;
    logic [CNT_W-1:0]   m_value_count;
    logic [IDX_W-1:0]   m_start_index;
    logic [4*VAL_W-1:0] m_values_front;
    logic [4*VAL_W-1:0] m_values_back;
    logic               m_last;

    // Mirror of the block state
    logic [DATA_W-1:0]  bin_mirror [BIN_COUNT];
    logic [SHIFT_W-1:0] output_shift;
    logic [IDX_W-1:0]   bin_after_range;
    logic [FRM_W-1:0]   frames_in_last_range;

    bin_frame_t  expected_frames [$];
    int unsigned error_count    = 0;
    int unsigned requests_sent  = 0;
    int unsigned frames_checked = 0;
    int unsigned shift_writes   = 0;
    int unsigned hold_off_len   = 0;
    bit          idle_en        = 1'b1;

    spectrum_bin_readout_framer i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_command_code (s_command_code),
        .s_first_bin    (s_first_bin),
        .s_last_bin     (s_last_bin),
        .s_bin_data     (s_bin_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reply_kind   (m_reply_kind),
        .m_status_code  (m_status_code),
        .m_frame_total  (m_frame_total),
        .m_frame_number (m_frame_number),
        .m_value_count  (m_value_count),
        .m_start_index  (m_start_index),
        .m_values_front (m_values_front),
        .m_values_back  (m_values_back),
        .m_last         (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idle_en || roll < 60) begin
            return 0;
        end
        if (roll < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Arithmetic shift, negative bins clamp to zero, large ones to 65535
    function automatic logic [VAL_W-1:0] scaled_bin(input logic [DATA_W-1:0] raw);
        logic [DATA_W-1:0] shifted;
        if (raw[DATA_W-1]) begin
            return '0;
        end
        shifted = raw >> output_shift;
        if (shifted > DATA_W'(16'hFFFF)) begin
            return '1;
        end
        return shifted[VAL_W-1:0];
    endfunction

    // Update the mirror and queue the frames one accepted request produces
    function automatic void predict_request(input logic              func,
                                            input logic [CMD_W-1:0]  cmd,
                                            input logic [IDX_W-1:0]  first,
                                            input logic [IDX_W-1:0]  last,
                                            input logic [DATA_W-1:0] data);
        bin_frame_t  f;
        int unsigned span;
        int unsigned frames;
        int unsigned idx;
        int unsigned cnt;
        f      = '0;
        f.last = 1'b1;
        if (func == FUNC_WRITE) begin
            if (first < BIN_COUNT) begin
                bin_mirror[first] = data;
            end
            return;
        end
        if (cmd == CMD_SINGLE) begin
            if (first >= BIN_COUNT) begin
                f.kind = KIND_ERROR;
                f.err  = ERR_BAD_ARG;
            end else begin
                f.kind   = KIND_SINGLE;
                f.total  = 1;
                f.number = 1;
                f.count  = 1;
                f.start  = first;
                f.front  = {scaled_bin(bin_mirror[first]), 48'h0};
            end
            expected_frames.push_back(f);
            return;
        end
        if (cmd != CMD_RANGE) begin
            f.kind = KIND_ERROR;
            f.err  = ERR_BAD_CMD;
            expected_frames.push_back(f);
            return;
        end
        // reversed range, end past the store, or more frames than a reply holds
        span   = int'(last) - int'(first) + 1;
        frames = (span + VALUES_PER_FRAME - 1) / VALUES_PER_FRAME;
        if (first > last || last >= BIN_COUNT || frames > MAX_FRAMES) begin
            f.kind = KIND_ERROR;
            f.err  = ERR_BAD_ARG;
            expected_frames.push_back(f);
            return;
        end
        idx = first;
        for (int unsigned n = 1; n <= frames; n++) begin
            cnt = int'(last) - idx + 1;
            if (cnt > VALUES_PER_FRAME) begin
                cnt = VALUES_PER_FRAME;
            end
            f        = '0;
            f.kind   = KIND_RANGE;
            f.total  = FRM_W'(frames);
            f.number = FRM_W'(n);
            f.count  = CNT_W'(cnt);
            f.start  = IDX_W'(idx);
            f.last   = (n == frames);
            for (int unsigned i = 0; i < cnt; i++) begin
                if (i < 4) begin
                    f.front[63 - 16*i -: 16] = scaled_bin(bin_mirror[idx + i]);
                end else begin
                    f.back[63 - 16*(i-4) -: 16] = scaled_bin(bin_mirror[idx + i]);
                end
            end
            expected_frames.push_back(f);
            idx += cnt;
        end
        bin_after_range      = IDX_W'(idx);
        frames_in_last_range = FRM_W'(frames);
    endfunction

    // Present one request after a random gap and hold it until accepted
    task automatic send_request(input logic              func,
                                input logic [CMD_W-1:0]  cmd,
                                input logic [IDX_W-1:0]  first,
                                input logic [IDX_W-1:0]  last,
                                input logic [DATA_W-1:0] data);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= func;
        s_command_code <= cmd;
        s_first_bin    <= first;
        s_last_bin     <= last;
        s_bin_data     <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(func, cmd, first, last, data);
        requests_sent++;
    endtask

    // Stop sending and wait until every expected frame is in, plus write retirement
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_output_shift(input logic [SHIFT_W-1:0] value);
        wait_for_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        output_shift = value;
        shift_writes++;
    endtask

    function automatic logic [DATA_W-1:0] pick_bin_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return $urandom >> $urandom_range(1, 31);
            // around the saturation point for the current shift
            4:       return (32'd65536 << output_shift) - 32'd1 + $urandom_range(0, 2);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(input int unsigned window_base);
        if ($urandom_range(0, 9) < 7) begin
            return IDX_W'(window_base + $urandom_range(0, 31));
        end
        return IDX_W'($urandom_range(0, BIN_COUNT - 1));
    endfunction

    task automatic send_random_request(input int unsigned window_base);
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
        int unsigned      roll;
        int unsigned      span;
        roll  = $urandom_range(0, 99);
        first = pick_index(window_base);
        if (roll < 52) begin
            send_request(FUNC_WRITE, CMD_W'($urandom), first, IDX_W'($urandom),
                         pick_bin_value());
        end else if (roll < 72) begin
            send_request(FUNC_HOST, CMD_SINGLE, first, IDX_W'($urandom), $urandom);
        end else if (roll < 90) begin
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(1, BIN_COUNT)
                                               : $urandom_range(1, 20);
            last = (first + span - 1 > BIN_COUNT - 1) ? IDX_W'(BIN_COUNT - 1)
                                                      : IDX_W'(first + span - 1);
            send_request(FUNC_HOST, CMD_RANGE, first, last, $urandom);
        end else if (roll < 94) begin
            first = IDX_W'($urandom_range(1, BIN_COUNT - 1));
            last  = IDX_W'($urandom_range(0, first - 1));
            send_request(FUNC_HOST, CMD_RANGE, first, last, $urandom);
        end else begin
            send_request(FUNC_HOST, CMD_W'($urandom_range(2, 255)), first,
                         IDX_W'($urandom), $urandom);
        end
    endtask

    // Field extremes, every command, reversed ranges and negative bins
    task automatic test_directed_extremes();
        // store is all zero after reset
        send_request(FUNC_HOST, CMD_SINGLE, 8'd0, 8'd0, '0);
        send_request(FUNC_HOST, CMD_RANGE, 8'd0, 8'd255, '0);
        send_request(FUNC_WRITE, CMD_SINGLE, 8'd0, 8'd0, 32'h7FFF_FFFF);
        send_request(FUNC_WRITE, CMD_SINGLE, 8'd255, 8'd0, 32'h8000_0000);
        send_request(FUNC_WRITE, CMD_SINGLE, 8'd1, 8'd0, 32'hFFFF_FFFF);
        send_request(FUNC_WRITE, CMD_SINGLE, 8'd2, 8'd0, 32'h0FFF_F000);
        send_request(FUNC_WRITE, CMD_SINGLE, 8'd3, 8'd0, 32'h1000_0000);
        send_request(FUNC_WRITE, CMD_SINGLE, 8'd254, 8'd0, 32'h0000_1FFF);
        // command code is a don't-care on a write
        send_request(FUNC_WRITE, 8'hFF, 8'd4, 8'hFF, 32'h0001_2345);
        send_request(FUNC_HOST, CMD_SINGLE, 8'd0, 8'd0, '0);
        send_request(FUNC_HOST, CMD_SINGLE, 8'd255, 8'd0, '0);
        send_request(FUNC_HOST, CMD_SINGLE, 8'd1, 8'd0, '0);
        send_request(FUNC_HOST, CMD_SINGLE, 8'd2, 8'd0, '0);
        send_request(FUNC_HOST, CMD_SINGLE, 8'd3, 8'd0, '0);
        // one full frame, a one-value tail frame, the top end, single-bin ranges
        send_request(FUNC_HOST, CMD_RANGE, 8'd0, 8'd7, '0);
        send_request(FUNC_HOST, CMD_RANGE, 8'd0, 8'd8, '0);
        send_request(FUNC_HOST, CMD_RANGE, 8'd250, 8'd255, '0);
        send_request(FUNC_HOST, CMD_RANGE, 8'd255, 8'd255, '0);
        send_request(FUNC_HOST, CMD_RANGE, 8'd0, 8'd0, '0);
        // reversed ranges
        send_request(FUNC_HOST, CMD_RANGE, 8'd5, 8'd4, '0);
        send_request(FUNC_HOST, CMD_RANGE, 8'd255, 8'd0, '0);
        // unknown commands
        send_request(FUNC_HOST, 8'd2, 8'd0, 8'd0, '0);
        send_request(FUNC_HOST, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    endtask

    // Shift extremes on the same bins
    task automatic test_shift_settings();
        logic [SHIFT_W-1:0] shifts [3];
        shifts = '{SHIFT_W'(0), SHIFT_W'(31), SHIFT_W'($urandom_range(1, 30))};
        foreach (shifts[k]) begin
            set_output_shift(shifts[k]);
            send_request(FUNC_HOST, CMD_SINGLE, 8'd0, 8'd0, '0);
            send_request(FUNC_HOST, CMD_SINGLE, 8'd254, 8'd0, '0);
            send_request(FUNC_HOST, CMD_RANGE, 8'd0, 8'd7, '0);
        end
    endtask

    task automatic test_random_traffic();
        int unsigned window_base;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_output_shift(SHIFT_W'($urandom_range(0, 31)));
            idle_en     = (p != 2);
            window_base = $urandom_range(0, BIN_COUNT - 32);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // sender pause until the block has answered everything
                if (p == 1 && n == PHASE_REQUESTS / 2) begin
                    wait_for_drain();
                end
                send_random_request(window_base);
            end
        end
        idle_en = 1'b1;
    endtask

    // Receiver holds off while long range reads keep coming
    task automatic test_result_backpressure();
        logic [IDX_W-1:0] first;
        wait_for_drain();
        idle_en      = 1'b0;
        hold_off_len = HOLD_OFF_CYCLES;
        for (int n = 0; n < 12; n++) begin
            first = IDX_W'($urandom_range(0, 128));
            send_request(FUNC_HOST, CMD_RANGE, first,
                         IDX_W'(first + $urandom_range(63, 127)), $urandom);
        end
        idle_en = 1'b1;
    endtask

    // Receiver: random stalls, plus a counted hold-off on request
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_len != 0) begin
                stall_left   = hold_off_len;
                hold_off_len = 0;
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready    <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_result();
        bin_frame_t want;
        if (expected_frames.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d start %0d",
                     $time, m_reply_kind, m_start_index);
            error_count++;
            return;
        end
        want = expected_frames.pop_front();
        frames_checked++;
        check_field("reply_kind", want.kind, m_reply_kind);
        check_field("status_code", want.err, m_status_code);
        check_field("frame_total", want.total, m_frame_total);
        check_field("frame_number", want.number, m_frame_number);
        check_field("value_count", want.count, m_value_count);
        check_field("start_index", want.start, m_start_index);
        check_field("values_front", want.front, m_values_front);
        check_field("values_back", want.back, m_values_back);
        check_field("last", want.last, m_last);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result();
        end
    end

    initial begin
        #50_000_000;
        $display("spectrum_bin_readout_framer_tb failed");
        $finish;
    end

    initial begin
        foreach (bin_mirror[b]) begin
            bin_mirror[b] = '0;
        end
        output_shift         = SHIFT_RESET;
        bin_after_range      = '0;
        frames_in_last_range = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_shift_settings();
        test_random_traffic();
        test_result_backpressure();
        wait_for_drain();

        if (expected_frames.size() != 0) begin
            $display("%0t: %0d expected frames never arrived", $time,
                     expected_frames.size());
            error_count++;
        end
        $display("Sent %0d requests, checked %0d replies/frames over %0d shift settings,",
                 requests_sent, frames_checked, shift_writes);
        $display("including a %0d-cycle receiver hold-off with the input stalled.",
                 HOLD_OFF_CYCLES);
        if (error_count == 0) begin
            $display("spectrum_bin_readout_framer_tb passed");
        end else begin
            $display("spectrum_bin_readout_framer_tb failed");
        end
        $finish;
    end

endmodule
